[hw/rtl/date_token_recognizer_macros.svh]
// Assertion macros used by the date token recognizer RTL.
`ifndef DATE_TOKEN_RECOGNIZER_MACROS_SVH
`define DATE_TOKEN_RECOGNIZER_MACROS_SVH
`ifndef SYNTHESIS
// Property that must hold at every edge outside reset.
`define DTR_ASSERT(label, clk, rst, prop) \
   label: assert property (@(posedge clk) disable iff (rst) (prop)) \
      else $error("date token recognizer: check failed");
// Condition in one cycle implies a condition in the next.
`define DTR_ASSERT_NEXT(label, clk, rst, pre, post) \
   label: assert property (@(posedge clk) disable iff (rst) (pre) |=> (post)) \
      else $error("date token recognizer: check failed");
`else
`define DTR_ASSERT(label, clk, rst, prop)
`define DTR_ASSERT_NEXT(label, clk, rst, pre, post)
`endif
`endif

[hw/rtl/dtr_pkg.sv]
// Types, constants and helper functions of the date token recognizer.
package dtr_pkg;

   localparam int CHAR_BITS = 21;
   localparam int WIN_DEPTH = 12;
   localparam int CNT_BITS  = $clog2(WIN_DEPTH + 1);
   localparam int KEY_BITS  = 22;
   localparam int YEAR_BITS = 14;

   // Characters the sentence must hold, newest included, for each form.
   localparam int MIN_NUMERIC = 11;
   localparam int MIN_NAMED   = 12;

   typedef logic [CHAR_BITS-1:0]          char_type;
   typedef char_type [WIN_DEPTH-1:0]      window_type;  // index 0 is the newest
   typedef logic [CNT_BITS-1:0]           count_type;
   typedef logic [KEY_BITS-1:0]           key_type;

   localparam logic [1:0] FMT_SLASH = 2'd0;
   localparam logic [1:0] FMT_DASH  = 2'd1;
   localparam logic [1:0] FMT_NAME  = 2'd2;

   localparam char_type CH_SPACE  = CHAR_BITS'(8'h20);
   localparam char_type CH_PERIOD = CHAR_BITS'(8'h2E);
   localparam char_type CH_SLASH  = CHAR_BITS'(8'h2F);
   localparam char_type CH_DASH   = CHAR_BITS'(8'h2D);
   localparam char_type CH_ZERO   = CHAR_BITS'(8'h30);
   localparam char_type CH_NINE   = CHAR_BITS'(8'h39);

   localparam key_type KEY_MONTH_MULT = KEY_BITS'(31);
   localparam key_type KEY_YEAR_MULT  = KEY_BITS'(365);

   localparam logic [4:0] MONTH_LEN [13] =
      '{5'd0, 5'd31, 5'd28, 5'd31, 5'd30, 5'd31, 5'd30,
        5'd31, 5'd31, 5'd30, 5'd31, 5'd30, 5'd31};

   localparam logic [23:0] MONTH_NAMES [12] =
      '{"Jan", "Feb", "Mar", "Apr", "May", "Jun",
        "Jul", "Aug", "Sep", "Oct", "Nov", "Dec"};

   // Result of one window scan, passed between the scanner and the pipeline.
   typedef struct packed {
      logic                 found;
      logic [1:0]           fmt;
      logic [4:0]           day;
      logic [3:0]           month;
      logic [YEAR_BITS-1:0] year;
   } date_fields_type;

   function automatic logic is_digit(input char_type c);
      return (c >= CH_ZERO) && (c <= CH_NINE);
   endfunction

   function automatic logic is_term(input char_type c);
      return (c == CH_SPACE) || (c == CH_PERIOD);
   endfunction

   // Low nibble of an ASCII digit is its value.
   function automatic logic [3:0] dig(input char_type c);
      return c[3:0];
   endfunction

   function automatic logic [6:0] two_digit(input char_type hi, input char_type lo);
      return 7'(dig(hi)) * 7'd10 + 7'(dig(lo));
   endfunction

   function automatic logic [YEAR_BITS-1:0] four_digit(input char_type d3, input char_type d2,
                                                        input char_type d1, input char_type d0);
      return YEAR_BITS'(dig(d3)) * YEAR_BITS'(1000) + YEAR_BITS'(dig(d2)) * YEAR_BITS'(100)
           + YEAR_BITS'(dig(d1)) * YEAR_BITS'(10) + YEAR_BITS'(dig(d0));
   endfunction

   // Leap rule on the digits: 10*a + b is divisible by 4 iff 2*a + b is.
   function automatic logic leap_year(input char_type d3, input char_type d2,
                                      input char_type d1, input char_type d0);
      logic [4:0] lo;
      logic [4:0] hi;
      logic       cent;
      lo   = {dig(d1), 1'b0} + 5'(dig(d0));
      hi   = {dig(d3), 1'b0} + 5'(dig(d2));
      cent = (dig(d1) == 4'd0) && (dig(d0) == 4'd0);
      return ((lo[1:0] == 2'd0) && !cent) || (cent && (hi[1:0] == 2'd0));
   endfunction

   function automatic logic valid_date(input logic [6:0] day, input logic [6:0] month,
                                       input logic leap);
      logic ok;
      if (leap && (month == 7'd2) && (day == 7'd29)) begin
         ok = 1'b1;
      end else if ((day == 7'd0) || (month == 7'd0) || (month > 7'd12)) begin
         ok = 1'b0;
      end else begin
         ok = day <= 7'(MONTH_LEN[month[3:0]]);
      end
      return ok;
   endfunction

   // Month number for a three-letter name, 0 when it is none.
   function automatic logic [3:0] month_of_name(input char_type c0, input char_type c1,
                                                input char_type c2);
      logic [3:0] m;
      m = 4'd0;
      for (int k = 0; k < 12; k++) begin
         if ((c0 == CHAR_BITS'(MONTH_NAMES[k][23:16])) &&
             (c1 == CHAR_BITS'(MONTH_NAMES[k][15:8])) &&
             (c2 == CHAR_BITS'(MONTH_NAMES[k][7:0]))) begin
            m = 4'(k + 1);
         end
      end
      return m;
   endfunction

endpackage

[hw/rtl/date_token_recognizer.sv]
// Top level of the date token recognizer: window, scan and result pipeline.
//
//  channel  dir  handshake           payload
//  req      in   req_valid/req_stall  req_char_code, req_end_of_sentence
//  rsp      out  rsp_valid/rsp_stall  rsp_date_format .. rsp_is_past
//  csr      in   csr_valid/csr_ready  csr_today_key
//
// One character is taken every cycle while req_stall is low. A found date
// passes from the window scan into the field register, then through the key
// multiply-add and the past compare into the output register, which drives
// rsp. Characters that close no date give no item.
// Reset (synchronous) empties the window, zeroes today_key and drops results.
// req_stall rises only when both the field register and a stalled output
// item are full; csr_ready is always high.
`include "date_token_recognizer_macros.svh"

module date_token_recognizer (
   input  logic                           clock,
   input  logic                           reset,
   input  logic                           req_valid,
   output logic                           req_stall,
   input  logic [20:0]                    req_char_code,
   input  logic                           req_end_of_sentence,
   output logic                           rsp_valid,
   input  logic                           rsp_stall,
   output logic [1:0]                     rsp_date_format,
   output logic [4:0]                     rsp_day_value,
   output logic [3:0]                     rsp_month_value,
   output logic [dtr_pkg::YEAR_BITS-1:0]  rsp_year_value,
   output logic [dtr_pkg::KEY_BITS-1:0]   rsp_date_key,
   output logic                           rsp_is_past,
   input  logic                           csr_valid,
   output logic                           csr_ready,
   input  logic [dtr_pkg::KEY_BITS-1:0]   csr_today_key
);
   import dtr_pkg::*;

   // sentence window and fill count
   window_type      win_ff, win_in, win_shift;
   count_type       cnt_ff, cnt_in, cnt_next;
   key_type         today_ff, today_in;

   // field register between scan and key stage
   date_fields_type scan_fields;
   date_fields_type s1_ff, s1_in;
   logic            s1_valid_ff, s1_valid_in;

   // output register
   logic                 out_valid_ff, out_valid_in;
   logic [1:0]           fmt_ff, fmt_in;
   logic [4:0]           day_ff, day_in;
   logic [3:0]           mon_ff, mon_in;
   logic [YEAR_BITS-1:0] year_ff, year_in;
   key_type              key_ff, key_in, key_calc;
   logic                 past_ff, past_in;

   logic req_acc;
   logic out_move;
   logic out_date_ok;

   // output slot frees when empty or taken this cycle
   assign out_move  = !out_valid_ff || !rsp_stall;
   assign req_stall = s1_valid_ff && !out_move;
   assign req_acc   = req_valid && !req_stall;
   assign csr_ready = 1'b1;

   // newest character enters at index 0, oldest falls off the top
   assign win_shift = {win_ff[WIN_DEPTH-2:0], req_char_code[CHAR_BITS-1:0]};
   assign cnt_next  = (cnt_ff < CNT_BITS'(WIN_DEPTH)) ? cnt_ff + 1'b1 : cnt_ff;

   dtr_scan u_scan (
      .win    (win_shift),
      .count  (cnt_next),
      .fields (scan_fields)
   );

   assign key_calc = KEY_BITS'(s1_ff.month) * KEY_MONTH_MULT
                   + KEY_BITS'(s1_ff.year) * KEY_YEAR_MULT
                   + KEY_BITS'(s1_ff.day);

   always_comb begin
      win_in   = win_ff;
      cnt_in   = cnt_ff;
      today_in = today_ff;
      if (csr_valid && csr_ready) begin
         today_in = csr_today_key;
      end
      if (req_acc) begin
         // the end-marked character is scanned, then the sentence restarts
         win_in = req_end_of_sentence ? '0 : win_shift;
         cnt_in = req_end_of_sentence ? '0 : cnt_next;
      end

      s1_in       = s1_ff;
      s1_valid_in = s1_valid_ff && !out_move;
      if (req_acc && scan_fields.found) begin
         s1_in       = scan_fields;
         s1_valid_in = 1'b1;
      end

      out_valid_in = out_valid_ff && rsp_stall;
      fmt_in  = fmt_ff;
      day_in  = day_ff;
      mon_in  = mon_ff;
      year_in = year_ff;
      key_in  = key_ff;
      past_in = past_ff;
      if (s1_valid_ff && out_move) begin
         out_valid_in = 1'b1;
         fmt_in  = s1_ff.fmt;
         day_in  = s1_ff.day;
         mon_in  = s1_ff.month;
         year_in = s1_ff.year;
         key_in  = key_calc;
         past_in = today_ff > key_calc;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         win_ff       <= '0;
         cnt_ff       <= '0;
         today_ff     <= '0;
         s1_valid_ff  <= 1'b0;
         out_valid_ff <= 1'b0;
      end else begin
         win_ff       <= win_in;
         cnt_ff       <= cnt_in;
         today_ff     <= today_in;
         s1_valid_ff  <= s1_valid_in;
         out_valid_ff <= out_valid_in;
      end
      s1_ff   <= s1_in;
      fmt_ff  <= fmt_in;
      day_ff  <= day_in;
      mon_ff  <= mon_in;
      year_ff <= year_in;
      key_ff  <= key_in;
      past_ff <= past_in;
   end

   assign rsp_valid       = out_valid_ff;
   assign rsp_date_format = fmt_ff;
   assign rsp_day_value   = day_ff;
   assign rsp_month_value = mon_ff;
   assign rsp_year_value  = year_ff;
   assign rsp_date_key    = key_ff;
   assign rsp_is_past     = past_ff;

   // month and day of a held result item lie in range
   assign out_date_ok = (mon_ff != 4'd0) && (mon_ff <= 4'd12) && (day_ff != 5'd0);

   `DTR_ASSERT(a_cnt_bound, clock, reset, cnt_ff <= CNT_BITS'(WIN_DEPTH))
   `DTR_ASSERT_NEXT(a_eos_clears, clock, reset, req_acc && req_end_of_sentence, cnt_ff == '0)
   `DTR_ASSERT(a_out_date_sane, clock, reset, !out_valid_ff || out_date_ok)
   `DTR_ASSERT_NEXT(a_s1_drains, clock, reset, s1_valid_ff && !out_valid_ff, out_valid_ff)

endmodule

[hw/rtl/dtr_scan.sv]
// Window scanner: finds a closed date at the newest character of the window.
module dtr_scan (
   input  dtr_pkg::window_type      win,
   input  dtr_pkg::count_type       count,
   output dtr_pkg::date_fields_type fields
);
   import dtr_pkg::*;

   logic                 term;
   logic                 slash_punct, dash_punct, name_punct;
   logic                 slash_ok, dash_ok, name_ok;
   logic [6:0]           s_day, s_mon, d_day, d_mon, n_day;
   logic [YEAR_BITS-1:0] s_year, d_year, n_year;
   logic [3:0]           n_mon;

   always_comb begin
      term        = is_term(win[0]);
      slash_punct = (win[8] == CH_SLASH) && (win[5] == CH_SLASH);
      dash_punct  = (win[6] == CH_DASH) && (win[3] == CH_DASH);
      name_punct  = (win[9] == CH_SPACE) && (win[5] == CH_SPACE);

      s_day  = two_digit(win[10], win[9]);
      s_mon  = two_digit(win[7], win[6]);
      s_year = four_digit(win[4], win[3], win[2], win[1]);
      slash_ok = is_digit(win[10]) && is_digit(win[9]) && is_digit(win[7]) &&
                 is_digit(win[6]) && is_digit(win[4]) && is_digit(win[3]) &&
                 is_digit(win[2]) && is_digit(win[1]) &&
                 valid_date(s_day, s_mon, leap_year(win[4], win[3], win[2], win[1]));

      d_year = four_digit(win[10], win[9], win[8], win[7]);
      d_mon  = two_digit(win[5], win[4]);
      d_day  = two_digit(win[2], win[1]);
      dash_ok = is_digit(win[10]) && is_digit(win[9]) && is_digit(win[8]) &&
                is_digit(win[7]) && is_digit(win[5]) && is_digit(win[4]) &&
                is_digit(win[2]) && is_digit(win[1]) &&
                valid_date(d_day, d_mon, leap_year(win[10], win[9], win[8], win[7]));

      n_mon  = month_of_name(win[8], win[7], win[6]);
      n_day  = two_digit(win[11], win[10]);
      n_year = s_year;
      name_ok = (n_mon != 4'd0) && is_digit(win[11]) && is_digit(win[10]) &&
                is_digit(win[4]) && is_digit(win[3]) && is_digit(win[2]) &&
                is_digit(win[1]) &&
                valid_date(n_day, 7'(n_mon), leap_year(win[4], win[3], win[2], win[1]));

      fields = '0;
      // Slash punctuation shadows the dash form even when its digits fail.
      if ((count >= CNT_BITS'(MIN_NUMERIC)) && term && slash_punct && slash_ok) begin
         fields.found = 1'b1;
         fields.fmt   = FMT_SLASH;
         fields.day   = s_day[4:0];
         fields.month = s_mon[3:0];
         fields.year  = s_year;
      end else if ((count >= CNT_BITS'(MIN_NUMERIC)) && term && !slash_punct &&
                   dash_punct && dash_ok) begin
         fields.found = 1'b1;
         fields.fmt   = FMT_DASH;
         fields.day   = d_day[4:0];
         fields.month = d_mon[3:0];
         fields.year  = d_year;
      end else if ((count >= CNT_BITS'(MIN_NAMED)) && term && name_punct && name_ok) begin
         fields.found = 1'b1;
         fields.fmt   = FMT_NAME;
         fields.day   = n_day[4:0];
         fields.month = n_mon;
         fields.year  = n_year;
      end
   end

endmodule

[bench/testbench.sv]
// Self-checking bench for the date token recognizer: directed and random text streams.
module testbench;

   // Character codes the bench builds text from.
   localparam logic [20:0] CH_SP    = 21'h20;
   localparam logic [20:0] CH_DOT   = 21'h2E;
   localparam logic [20:0] CH_SLASH = 21'h2F;
   localparam logic [20:0] CH_DASH  = 21'h2D;
   localparam logic [20:0] CH_ZERO  = 21'h30;
   localparam logic [20:0] CH_NINE  = 21'h39;
   localparam logic [20:0] CH_MAX   = 21'h10FFFF;   // top Unicode code point

   localparam logic [21:0] KEY_TOP   = 22'd3650038;  // 31/12/9999
   localparam logic [21:0] KEY_MID   = 22'd730201;   // 15/06/2000

   localparam int SETTLE_CYCLES = 6;     // pipeline is two deep, plus margin
   localparam int DRAIN_LIMIT   = 5000;  // cycles to wait for results before giving up
   localparam int HOLD_CYCLES   = 150;   // long receiver hold-off
   localparam int SHOW_LIMIT    = 10;    // mismatches printed in full

   // One found date, as the result channel carries it.
   typedef struct packed {
      logic [1:0]                   fmt;
      logic [4:0]                   day;
      logic [3:0]                   month;
      logic [dtr_pkg::YEAR_BITS-1:0] year;
      logic [dtr_pkg::KEY_BITS-1:0]  key;
      logic                         past;
   } found_date_type;

   logic clock = 1'b0;
   logic reset = 1'b1;

   logic                          req_valid = 1'b0;
   logic                          req_stall;
   logic [20:0]                   req_char_code = '0;
   logic                          req_end_of_sentence = 1'b0;
   logic                          rsp_valid;
   logic                          rsp_stall = 1'b0;
   logic [1:0]                    rsp_date_format;
   logic [4:0]                    rsp_day_value;
   logic [3:0]                    rsp_month_value;
   logic [dtr_pkg::YEAR_BITS-1:0] rsp_year_value;
   logic [dtr_pkg::KEY_BITS-1:0]  rsp_date_key;
   logic                          rsp_is_past;
   logic                          csr_valid = 1'b0;
   logic                          csr_ready;
   logic [dtr_pkg::KEY_BITS-1:0]  csr_today_key = '0;

   // Shadow of the block: sentence window (index 0 newest), its fill count, today.
   logic [20:0] hist [12];
   int          held = 0;
   logic [21:0] today_model = '0;

   found_date_type pending_dates [$];   // dates still owed by the block, oldest first
   int             error_count = 0;
   int             chars_sent  = 0;

   // Pacing knobs, set per phase.
   bit   req_pace = 1'b0;
   bit   rsp_pace = 1'b0;
   logic rsp_hold = 1'b0;            // long hold-off, timed by its own process
   int   stall_left = 0;

   date_token_recognizer i_dut (
      .clock               (clock),
      .reset               (reset),
      .req_valid           (req_valid),
      .req_stall           (req_stall),
      .req_char_code       (req_char_code),
      .req_end_of_sentence (req_end_of_sentence),
      .rsp_valid           (rsp_valid),
      .rsp_stall           (rsp_stall),
      .rsp_date_format     (rsp_date_format),
      .rsp_day_value       (rsp_day_value),
      .rsp_month_value     (rsp_month_value),
      .rsp_year_value      (rsp_year_value),
      .rsp_date_key        (rsp_date_key),
      .rsp_is_past         (rsp_is_past),
      .csr_valid           (csr_valid),
      .csr_ready           (csr_ready),
      .csr_today_key       (csr_today_key)
   );

   always #10 clock = ~clock;

   initial begin
      for (int k = 0; k < 12; k++) hist[k] = '0;
   end

   // ---------------------------------------------------------------------
   // Date predictor
   // ---------------------------------------------------------------------

   function automatic bit is_stop(input logic [20:0] c);
      return (c == CH_SP) || (c == CH_DOT);
   endfunction

   // n digits read oldest first, starting d places back in the window.
   function automatic bit digits_at(input int d, input int n, output int v);
      logic [20:0] c;
      v = 0;
      for (int k = 0; k < n; k++) begin
         c = hist[d - k];
         if ((c < CH_ZERO) || (c > CH_NINE)) return 1'b0;
         v = v * 10 + int'(c - CH_ZERO);
      end
      return 1'b1;
   endfunction

   function automatic int days_in(input int m);
      case (m)
         2:             return 28;
         4, 6, 9, 11:   return 30;
         default:       return 31;
      endcase
   endfunction

   function automatic bit real_date(input int d, input int m, input int y);
      bit leap;
      leap = ((y % 4 == 0) && (y % 100 != 0)) || (y % 400 == 0);
      if (leap && (m == 2) && (d == 29)) return 1'b1;
      if ((d == 0) || (m == 0) || (m > 12)) return 1'b0;
      return d <= days_in(m);
   endfunction

   // Month number of a case-sensitive three-letter name, 0 for none.
   function automatic int name_month(input logic [20:0] a, input logic [20:0] b,
                                     input logic [20:0] c);
      if ((a[20:8] != 0) || (b[20:8] != 0) || (c[20:8] != 0)) return 0;
      case ({a[7:0], b[7:0], c[7:0]})
         "Jan":   return 1;
         "Feb":   return 2;
         "Mar":   return 3;
         "Apr":   return 4;
         "May":   return 5;
         "Jun":   return 6;
         "Jul":   return 7;
         "Aug":   return 8;
         "Sep":   return 9;
         "Oct":   return 10;
         "Nov":   return 11;
         "Dec":   return 12;
         default: return 0;
      endcase
   endfunction

   // Shift one accepted character into the shadow window; return 1 with the
   // date it closes, if any.
   function automatic bit predict_date(input logic [20:0] c, input logic eos,
                                       output found_date_type r);
      int         d;
      int         m;
      int         y;
      int         key;
      bit         hit;
      logic [1:0] f;
      hit = 1'b0;
      d = 0;
      m = 0;
      y = 0;
      f = dtr_pkg::FMT_SLASH;
      for (int k = 11; k > 0; k--) hist[k] = hist[k-1];
      hist[0] = c;
      if (held < 12) held++;

      // Slash punctuation wins over dash: dash is only tried without it.
      if ((held >= 11) && is_stop(hist[0])) begin
         if ((hist[8] == CH_SLASH) && (hist[5] == CH_SLASH)) begin
            if (digits_at(10, 2, d) && digits_at(7, 2, m) && digits_at(4, 4, y) &&
                real_date(d, m, y)) begin
               f = dtr_pkg::FMT_SLASH;
               hit = 1'b1;
            end
         end else if ((hist[6] == CH_DASH) && (hist[3] == CH_DASH)) begin
            if (digits_at(10, 4, y) && digits_at(5, 2, m) && digits_at(2, 2, d) &&
                real_date(d, m, y)) begin
               f = dtr_pkg::FMT_DASH;
               hit = 1'b1;
            end
         end
      end
      // Month-name form needs a full window.
      if (!hit && (held >= 12) && is_stop(hist[0]) && (hist[9] == CH_SP) &&
          (hist[5] == CH_SP)) begin
         m = name_month(hist[8], hist[7], hist[6]);
         if ((m != 0) && digits_at(11, 2, d) && digits_at(4, 4, y) &&
             real_date(d, m, y)) begin
            f = dtr_pkg::FMT_NAME;
            hit = 1'b1;
         end
      end

      // End-marked character was scanned above; now the sentence starts over.
      if (eos) begin
         for (int k = 0; k < 12; k++) hist[k] = '0;
         held = 0;
      end

      key     = 31 * m + 365 * y + d;
      r.fmt   = f;
      r.day   = d[4:0];
      r.month = m[3:0];
      r.year  = y[dtr_pkg::YEAR_BITS-1:0];
      r.key   = key[dtr_pkg::KEY_BITS-1:0];
      r.past  = today_model > r.key;
      return hit;
   endfunction

   // ---------------------------------------------------------------------
   // Pacing and drivers
   // ---------------------------------------------------------------------

   // Mostly short gaps, now and then a long one.
   function automatic int idle_len();
      if ($urandom_range(0, 9) == 0) return $urandom_range(8, 40);
      return $urandom_range(1, 3);
   endfunction

   // Send one character item; predict once it is taken.
   task automatic send_char(input logic [20:0] ch, input logic eos);
      int             gap;
      bit             hit;
      found_date_type r;
      gap = (req_pace && ($urandom_range(0, 3) == 0)) ? idle_len() : 0;
      if (gap != 0) begin
         req_valid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_valid           <= 1'b1;
      req_char_code       <= ch;
      req_end_of_sentence <= eos;
      @(posedge clock);
      while (req_stall) @(posedge clock);
      hit = predict_date(ch, eos, r);
      if (hit) pending_dates.push_back(r);
      chars_sent++;
   endtask

   // Send a string; eos_at marks a sentence end, bad_at swaps in another code.
   task automatic send_text(input string s, input int eos_at, input int bad_at,
                            input logic [20:0] bad_ch);
      logic [7:0]  b;
      logic [20:0] ch;
      for (int i = 0; i < s.len(); i++) begin
         b  = s[i];
         ch = (i == bad_at) ? bad_ch : {13'd0, b};
         send_char(ch, i == eos_at);
      end
   endtask

   // Wait until every owed date has come out, then let the pipeline empty.
   task automatic settle();
      int waited;
      req_valid <= 1'b0;
      waited = 0;
      while ((pending_dates.size() != 0) && (waited < DRAIN_LIMIT)) begin
         @(posedge clock);
         waited++;
      end
      repeat (SETTLE_CYCLES) @(posedge clock);
   endtask

   // today_key is only written with the block idle.
   task automatic write_today(input logic [21:0] key);
      settle();
      csr_valid     <= 1'b1;
      csr_today_key <= key;
      @(posedge clock);
      while (!csr_ready) @(posedge clock);
      csr_valid   <= 1'b0;
      today_model = key;
   endtask

   // Receiver pacing: random stalls when enabled, plus the long hold-off.
   always @(posedge clock) begin : rsp_pacer
      if (stall_left != 0) begin
         stall_left <= stall_left - 1;
         rsp_stall  <= 1'b1;
      end else if (rsp_pace && ($urandom_range(0, 3) == 0)) begin
         stall_left <= idle_len() - 1;
         rsp_stall  <= 1'b1;
      end else begin
         rsp_stall <= rsp_hold;
      end
   end

   // Each accepted result item against the oldest owed date.
   always @(posedge clock) begin : date_checker
      found_date_type want;
      if (!reset && (rsp_valid === 1'b1) && !rsp_stall) begin
         if (pending_dates.size() == 0) begin
            error_count++;
            if (error_count <= SHOW_LIMIT)
               $display("unexpected date item: fmt %0d %0d-%0d-%0d key %0d past %0d",
                        rsp_date_format, rsp_day_value, rsp_month_value, rsp_year_value,
                        rsp_date_key, rsp_is_past);
         end else begin
            want = pending_dates.pop_front();
            if ((rsp_date_format !== want.fmt) || (rsp_day_value !== want.day) ||
                (rsp_month_value !== want.month) || (rsp_year_value !== want.year) ||
                (rsp_date_key !== want.key) || (rsp_is_past !== want.past)) begin
               error_count++;
               if (error_count <= SHOW_LIMIT) begin
                  $display("date mismatch: expected fmt %0d %0d-%0d-%0d key %0d past %0d",
                           want.fmt, want.day, want.month, want.year, want.key, want.past);
                  $display("                    got fmt %0d %0d-%0d-%0d key %0d past %0d",
                           rsp_date_format, rsp_day_value, rsp_month_value,
                           rsp_year_value, rsp_date_key, rsp_is_past);
               end
            end
         end
      end
   end

   // ---------------------------------------------------------------------
   // Stimulus helpers
   // ---------------------------------------------------------------------

   function automatic string month_name(input int m);
      case (m)
         1:       return "Jan";
         2:       return "Feb";
         3:       return "Mar";
         4:       return "Apr";
         5:       return "May";
         6:       return "Jun";
         7:       return "Jul";
         8:       return "Aug";
         9:       return "Sep";
         10:      return "Oct";
         11:      return "Nov";
         default: return "Dec";
      endcase
   endfunction

   // Noise character: punctuation, digits, letters, any code point, or a
   // digit with high bits set so only the low byte looks right.
   function automatic logic [20:0] random_char();
      case ($urandom_range(0, 5))
         0:       return $urandom_range(0, 1) ? CH_SP : CH_DOT;
         1:       return CH_ZERO + 21'($urandom_range(0, 9));
         2:       return 21'($urandom_range(65, 122));
         3:       return $urandom_range(0, 1) ? CH_SLASH : CH_DASH;
         4:       return 21'($urandom_range(0, CH_MAX));
         default: return (21'($urandom_range(1, 16)) << 16) | (CH_ZERO + 21'($urandom_range(0, 9)));
      endcase
   endfunction

   // Mostly well-formed dates with random fields; some broken, some noise.
   task automatic send_random_text(input int target);
      int          kind;
      int          d;
      int          m;
      int          y;
      int          bad_at;
      int          eos_at;
      logic [1:0]  form;
      string       s;
      string       term;
      while (chars_sent < target) begin
         kind = $urandom_range(0, 9);
         if (kind < 8) begin
            form = 2'(kind % 3);
            m = ($urandom_range(0, 3) == 0) ? 2 : $urandom_range(1, 12);
            if ($urandom_range(0, 9) == 0) m = $urandom_range(0, 99);
            d = ($urandom_range(0, 7) == 0) ? $urandom_range(0, 99) : $urandom_range(1, 31);
            if ((m == 2) && $urandom_range(0, 1)) d = $urandom_range(27, 30);
            case ($urandom_range(0, 3))
               0:       y = $urandom_range(0, 9999);
               1:       y = 100 * $urandom_range(0, 99);
               2:       y = 4 * $urandom_range(0, 2499);
               default: y = $urandom_range(1990, 2030);
            endcase
            term = $urandom_range(0, 1) ? " " : ".";
            case (form)
               dtr_pkg::FMT_SLASH: s = $sformatf("%02d/%02d/%04d%s", d, m, y, term);
               dtr_pkg::FMT_DASH:  s = $sformatf("%04d-%02d-%02d%s", y, m, d, term);
               default: begin
                  if ((m < 1) || (m > 12)) m = $urandom_range(1, 12);
                  s = $sformatf("%02d %s %04d%s", d, month_name(m), y, term);
               end
            endcase
            bad_at = ($urandom_range(0, 7) == 0) ? $urandom_range(0, s.len() - 1) : -1;
            if ($urandom_range(0, 3) == 0) begin
               eos_at = s.len() - 1;
            end else if ($urandom_range(0, 15) == 0) begin
               eos_at = $urandom_range(0, s.len() - 1);   // sentence ends inside the date
            end else begin
               eos_at = -1;
            end
            send_text(s, eos_at, bad_at, random_char());
         end else begin
            repeat ($urandom_range(1, 6)) send_char(random_char(), $urandom_range(0, 7) == 0);
         end
      end
   endtask

   // ---------------------------------------------------------------------
   // Tests
   // ---------------------------------------------------------------------

   // Field extremes, leap rules, every month name, sentence ends, odd codes.
   task automatic test_directed();
      write_today(KEY_MID);
      req_pace = 1'b0;
      rsp_pace = 1'b0;
      send_text("01/01/0000 ", -1, -1, '0);
      send_text("31/12/9999.", -1, -1, '0);
      send_text("0000-02-29 ", -1, -1, '0);   // year zero is a leap year
      send_text("1900-02-29 ", -1, -1, '0);   // century, not leap
      send_text("2000-02-29.", -1, -1, '0);   // divisible by 400
      send_text("2023-02-29 ", -1, -1, '0);
      send_text("2024-02-30 ", -1, -1, '0);
      send_text("29 Feb 2024 ", -1, -1, '0);
      send_text("31 Apr 2020 ", -1, -1, '0);  // beyond month length
      send_text("00/05/2020 ", -1, -1, '0);
      send_text("15/00/2020 ", -1, -1, '0);
      send_text("15/13/2020 ", -1, -1, '0);
      send_text("1a/05/2020 ", -1, -1, '0);
      send_text("15 jan 2020 ", -1, -1, '0);  // names are case-sensitive
      send_text("20/1-/2-01 ", -1, -1, '0);   // slash punctuation blocks dash
      send_text("15/06/2000 ", -1, -1, '0);   // key equals today: not past
      send_text("14/06/2000 ", -1, -1, '0);
      for (int k = 1; k <= 12; k++)
         send_text($sformatf("%02d %s %04d.", k + 10, month_name(k), 1994 + k), -1, -1, '0);
      // Closing character ends the sentence: scanned, then cleared.
      send_text("05/06/2007.", 10, -1, '0);
      send_text("/2007 ", -1, -1, '0);
      // Sentence ends inside a date.
      send_text("01/02/2003 ", 3, -1, '0);
      // A sentence end, then exactly the characters the month-name form needs.
      send_text("01/01/2020 ", 10, -1, '0);
      send_text("01 Jan 2020 ", -1, -1, '0);
      // Low byte right, high bits set.
      send_text("01/05/2020 ", -1, 1, 21'h10031);
      send_text("01/05/2020 ", -1, 2, 21'h1002F);
      send_text("01 Jan 2020 ", -1, 3, 21'h1004A);
      send_text("01/05/2020 ", -1, 10, 21'h10020);
      send_char(CH_MAX, 1'b1);
      send_char('0, 1'b0);
   endtask

   // today_key at both ends of its range.
   task automatic test_today_extremes();
      write_today('0);
      send_text("31/12/9999 01/01/0000 0000-01-01.", -1, -1, '0);
      write_today(KEY_TOP);
      send_text("31/12/9999 01/01/0000 31 Dec 9999 0000-01-01.", -1, -1, '0);
   endtask

   // Receiver holds off while dates keep coming, so the block stalls its input.
   task automatic test_backpressure();
      write_today(KEY_MID);
      req_pace = 1'b0;
      rsp_pace = 1'b0;
      fork
         begin
            rsp_hold <= 1'b1;
            repeat (HOLD_CYCLES) @(posedge clock);
            rsp_hold <= 1'b0;
         end
      join_none
      for (int k = 0; k < 20; k++)
         send_text($sformatf("%02d/%02d/%04d ", k + 1, (k % 12) + 1, 1980 + k), -1, -1, '0);
      // Sender pauses until every date is out.
      settle();
      for (int k = 0; k < 6; k++)
         send_text($sformatf("%04d-%02d-%02d.", 1996 + k, k + 7, 28 - k), -1, -1, '0);
   endtask

   task automatic test_random_paced();
      write_today(22'($urandom_range(0, KEY_TOP)));
      req_pace = 1'b1;
      rsp_pace = 1'b1;
      send_random_text(chars_sent + 250);
   endtask

   task automatic test_random_steady();
      write_today(22'($urandom_range(0, KEY_TOP)));
      req_pace = 1'b0;
      rsp_pace = 1'b0;
      send_random_text(chars_sent + 150);
   endtask

   task automatic test_random_slow_sink();
      write_today(22'($urandom_range(0, KEY_TOP)));
      req_pace = 1'b0;
      rsp_pace = 1'b1;
      send_random_text(chars_sent + 250);
   endtask

   initial begin : run
      repeat (6) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);
      test_directed();
      test_today_extremes();
      test_backpressure();
      test_random_paced();
      test_random_steady();
      test_random_slow_sink();
      settle();
      repeat (SETTLE_CYCLES) @(posedge clock);
      if (pending_dates.size() != 0) begin
         $display("%0d dates never came out", pending_dates.size());
         error_count += pending_dates.size();
      end
      if (error_count == 0) begin
         $display("Verification passed");
      end else begin
         $display("Verification failed");
      end
      $finish;
   end

   // Hard stop, far beyond the slowest correct run.
   initial begin : watchdog
      #8000000;
      $display("Verification failed");
      $finish;
   end

endmodule
